// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define HVG_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define HVG_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/hvg_pkg.sv
package hvg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;

    // configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_TERRAIN_SIZE   = 3'd2;
    localparam logic [2:0] REG_HEIGHT_GAIN    = 3'd3;
    localparam logic [2:0] REG_INV_TWO_STEP_X = 3'd4;
    localparam logic [2:0] REG_INV_TWO_STEP_Z = 3'd5;
    localparam logic [2:0] REG_TEX_STEP_U     = 3'd6;
    localparam logic [2:0] REG_TEX_STEP_V     = 3'd7;

    typedef struct packed {
        logic [10:0] grid_width;
        logic [12:0] grid_height;
        logic [23:0] terrain_size;
        logic [23:0] height_gain;
        logic [23:0] inv_two_step_x;
        logic [23:0] inv_two_step_z;
        logic [24:0] tex_step_u;
        logic [24:0] tex_step_v;
    } cfg_t;

    // one vertex to evaluate: position, the four neighbour heights and its own
    typedef struct packed {
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
        logic [SAMPLE_BITS-1:0] hl;
        logic [SAMPLE_BITS-1:0] hr;
        logic [SAMPLE_BITS-1:0] hd;
        logic [SAMPLE_BITS-1:0] hu;
        logic [SAMPLE_BITS-1:0] hs;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

endpackage

// File: rtl/hvg_ram.sv
module hvg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hvg_front.sv
module hvg_front import hvg_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   restart,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,
    output job_push_t              push,
    input  logic                   fifo_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_RD0  = 3'd1;
    localparam logic [2:0] F_RD1  = 3'd2;
    localparam logic [2:0] F_RD2  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;
    localparam logic [2:0] F_WR   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       x_reg, x_next;
    logic [ROW_W-1:0]       z_reg, z_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [SAMPLE_BITS-1:0] c_reg, c_next;
    logic [SAMPLE_BITS-1:0] d_reg, d_next;
    logic [SAMPLE_BITS-1:0] r_reg, r_next;
    logic [SAMPLE_BITS-1:0] held0_reg, held0_next;
    logic [SAMPLE_BITS-1:0] held1_reg, held1_next;
    logic [SAMPLE_BITS-1:0] prevc_reg, prevc_next;
    logic [1:0]             jidx_reg, jidx_next;

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic        last_row, x_last, has_j1, has_j2;
    logic [COL_W-1:0] cur_raddr;
    logic [SAMPLE_BITS-1:0] cur_rdata, prev_rdata;
    logic        ram_we;
    logic [SAMPLE_BITS-1:0] prev_wdata;
    job_t        job;

    always_comb begin
        if (cfg.grid_width < 11'd2) begin
            w_eff = 11'd2;
        end else if (cfg.grid_width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = cfg.grid_width;
        end
        if (cfg.grid_height < 13'd2) begin
            h_eff = 13'd2;
        end else if (cfg.grid_height > 13'(MAX_ROWS)) begin
            h_eff = 13'(MAX_ROWS);
        end else begin
            h_eff = cfg.grid_height;
        end
    end

    assign last_row = ({1'b0, z_reg} == h_eff - 13'd1);
    assign x_last   = ({1'b0, x_reg} == w_eff - 11'd1);
    assign has_j1   = last_row && (x_reg != '0);
    assign has_j2   = last_row && x_last;

    assign s_tready  = (state_reg == F_IDLE);
    assign cur_raddr = (state_reg == F_RD1) ? x_reg + COL_W'(1) : x_reg;
    assign ram_we    = (state_reg == F_WR);
    assign prev_wdata = (z_reg == '0) ? smp_reg : c_reg;

    hvg_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_cur_row (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (x_reg),
        .wdata (smp_reg),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    hvg_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev_row (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (x_reg),
        .wdata (prev_wdata),
        .raddr (x_reg),
        .rdata (prev_rdata)
    );

    // vertex selection: the one above, then on the last row the left one and the corner
    always_comb begin
        job = '0;
        case (jidx_reg)
            2'd0: begin
                job.col  = x_reg;
                job.row  = z_reg - ROW_W'(1);
                job.hl   = (x_reg != '0) ? prevc_reg : c_reg;
                job.hr   = r_reg;
                job.hd   = d_reg;
                job.hu   = smp_reg;
                job.hs   = c_reg;
                job.last = !(has_j1 || has_j2);
            end
            2'd1: begin
                job.col  = x_reg - COL_W'(1);
                job.row  = z_reg;
                job.hl   = (x_reg >= COL_W'(2)) ? held1_reg : held0_reg;
                job.hr   = smp_reg;
                job.hd   = prevc_reg;
                job.hu   = held0_reg;
                job.hs   = held0_reg;
                job.last = !has_j2;
            end
            default: begin
                job.col  = x_reg;
                job.row  = z_reg;
                job.hl   = held0_reg;
                job.hr   = smp_reg;
                job.hd   = c_reg;
                job.hu   = smp_reg;
                job.hs   = smp_reg;
                job.last = 1'b1;
            end
        endcase
    end

    assign push.valid = (state_reg == F_PUSH) && !fifo_full;
    assign push.job   = job;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x_next     = x_reg;
        z_next     = z_reg;
        smp_next   = smp_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        prevc_next = prevc_reg;
        jidx_next  = jidx_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    smp_next = s_tdata;
                    x_next   = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
                    z_next   = ({1'b0, row_reg} >= h_eff) ? '0 : row_reg;
                    if ((({1'b0, row_reg} >= h_eff) ? '0 : row_reg) == '0) begin
                        state_next = F_WR;
                    end else begin
                        state_next = F_RD0;
                    end
                end
            end
            F_RD0: begin
                state_next = F_RD1;
            end
            F_RD1: begin
                c_next     = cur_rdata;
                d_next     = prev_rdata;
                state_next = F_RD2;
            end
            F_RD2: begin
                r_next     = x_last ? c_reg : cur_rdata;
                jidx_next  = 2'd0;
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!fifo_full) begin
                    if (jidx_reg == 2'd0 && has_j1) begin
                        jidx_next = 2'd1;
                    end else if (jidx_reg != 2'd2 && has_j2) begin
                        jidx_next = 2'd2;
                    end else begin
                        state_next = F_WR;
                    end
                end
            end
            F_WR: begin
                held1_next = held0_reg;
                held0_next = smp_reg;
                prevc_next = prev_wdata;
                if (x_last) begin
                    col_next = '0;
                    row_next = last_row ? '0 : z_reg + ROW_W'(1);
                end else begin
                    col_next = x_reg + COL_W'(1);
                    row_next = z_reg;
                end
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            held0_reg <= '0;
            held1_reg <= '0;
            jidx_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            jidx_reg  <= jidx_next;
        end
        x_reg     <= x_next;
        z_reg     <= z_next;
        smp_reg   <= smp_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        r_reg     <= r_next;
        prevc_reg <= prevc_next;
    end

endmodule

// File: rtl/hvg_job_fifo.sv
module hvg_job_fifo import hvg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  job_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output job_t      head
);

    localparam int DEPTH = 4;

    job_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign full  = (count_reg == 3'(DEPTH));
    assign empty = (count_reg == 3'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push.valid) - 3'(pop);
        end
    end

endmodule

// File: rtl/hvg_back.sv
module hvg_back import hvg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         fifo_empty,
    input  job_t         head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata,
    output logic         m_tlast
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_SQRT = 3'd2;
    localparam logic [2:0] B_DSET = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]  state_reg;
    job_t        job_reg;
    logic [15:0] dx_reg, dz_reg;
    logic        negx_reg, negz_reg, negu_reg, negv_reg;
    logic [3:0]  step_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic [24:0] qx_reg, qz_reg;
    logic [31:0] sx_reg, sz_reg;
    logic [63:0] l_reg, res_reg, bit_reg, acc_reg;
    logic [23:0] wy_reg, wx_reg, wz_reg;
    logic [15:0] tu_reg, tv_reg;
    logic [36:0] mu_reg, mv_reg;
    logic [4:0]  cnt_reg;
    logic [47:0] num_reg, dv_reg;
    logic [16:0] quo_reg, quo_next;
    logic [1:0]  dsel_reg;
    logic [14:0] nx_reg, nz_reg, ny_reg;
    logic        out_free;
    logic [63:0] sq_try, tmp_w;
    logic [31:0] root;

    function automatic logic [31:0] slope_sat(input logic [63:0] p);
        logic [63:0] t;
        t = (p + 64'd2048) >> 12;
        return (t > 64'h8000_0000) ? 32'h8000_0000 : t[31:0];
    endfunction

    function automatic logic [23:0] height_sat(input logic [63:0] p);
        logic [63:0] t;
        t = (p + 64'd32768) >> 16;
        return (t > 64'hFF_FFFF) ? 24'hFF_FFFF : t[23:0];
    endfunction

    function automatic logic [15:0] tex_sat(input logic [36:0] t);
        logic [37:0] v;
        v = ({1'b0, t} + 38'd128) >> 8;
        return (v > 38'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [36:0] centre_mag(input logic [36:0] t);
        return (t < 37'h80_0000) ? 37'h80_0000 - t : t - 37'h80_0000;
    endfunction

    function automatic logic [23:0] world_bits(input logic neg, input logic [63:0] sum);
        logic [63:0] w;
        logic [23:0] m;
        w = (sum + 64'h80_0000) >> 24;
        if (neg) begin
            m = (w > 64'h80_0000) ? 24'h80_0000 : w[23:0];
            return 24'd0 - m;
        end else begin
            return (w > 64'h7F_FFFF) ? 24'h7F_FFFF : w[23:0];
        end
    endfunction

    assign pop      = (state_reg == B_IDLE) && !fifo_empty;
    assign out_free = !m_tvalid || m_tready;
    assign root     = res_reg[31:0];
    assign sq_try   = res_reg + bit_reg;
    assign tmp_w    = acc_reg + (prod_reg << 18);

    always_comb begin
        case (step_reg)
            4'd0:    begin mul_a = 32'(dx_reg);         mul_b = 32'(cfg.height_gain);    end
            4'd1:    begin mul_a = 32'(dz_reg);         mul_b = 32'(cfg.height_gain);    end
            4'd2:    begin mul_a = 32'(qx_reg);         mul_b = 32'(cfg.inv_two_step_x); end
            4'd3:    begin mul_a = 32'(qz_reg);         mul_b = 32'(cfg.inv_two_step_z); end
            4'd4:    begin mul_a = sx_reg;              mul_b = sx_reg;                  end
            4'd5:    begin mul_a = sz_reg;              mul_b = sz_reg;                  end
            4'd6:    begin mul_a = 32'(job_reg.hs);     mul_b = 32'(cfg.height_gain);    end
            4'd7:    begin mul_a = 32'(job_reg.col);    mul_b = 32'(cfg.tex_step_u);     end
            4'd8:    begin mul_a = 32'(job_reg.row);    mul_b = 32'(cfg.tex_step_v);     end
            4'd9:    begin mul_a = 32'(mu_reg[17:0]);   mul_b = 32'(cfg.terrain_size);   end
            4'd10:   begin mul_a = 32'(mu_reg[36:18]);  mul_b = 32'(cfg.terrain_size);   end
            4'd11:   begin mul_a = 32'(mv_reg[17:0]);   mul_b = 32'(cfg.terrain_size);   end
            4'd12:   begin mul_a = 32'(mv_reg[36:18]);  mul_b = 32'(cfg.terrain_size);   end
            default: begin mul_a = 32'd0;               mul_b = 32'd0;                   end
        endcase
    end

    assign quo_next = (num_reg >= dv_reg) ? {quo_reg[15:0], 1'b1} : {quo_reg[15:0], 1'b0};

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= B_IDLE;
            m_tvalid  <= 1'b0;
        end else begin
            if (state_reg == B_OUT && out_free) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!fifo_empty) begin
                        job_reg   <= head;
                        dx_reg    <= (head.hl > head.hr) ? head.hl - head.hr : head.hr - head.hl;
                        dz_reg    <= (head.hd > head.hu) ? head.hd - head.hu : head.hu - head.hd;
                        negx_reg  <= head.hr > head.hl;
                        negz_reg  <= head.hu > head.hd;
                        step_reg  <= 4'd0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1:  qx_reg <= 25'((prod_reg + 64'd32768) >> 16);
                        4'd2:  qz_reg <= 25'((prod_reg + 64'd32768) >> 16);
                        4'd3:  sx_reg <= slope_sat(prod_reg);
                        4'd4:  sz_reg <= slope_sat(prod_reg);
                        4'd5:  l_reg  <= prod_reg + 64'h1_0000_0000;
                        4'd6:  l_reg  <= l_reg + prod_reg;
                        4'd7:  wy_reg <= height_sat(prod_reg);
                        4'd8: begin
                            tu_reg   <= tex_sat(prod_reg[36:0]);
                            negu_reg <= prod_reg[36:0] < 37'h80_0000;
                            mu_reg   <= centre_mag(prod_reg[36:0]);
                        end
                        4'd9: begin
                            tv_reg   <= tex_sat(prod_reg[36:0]);
                            negv_reg <= prod_reg[36:0] < 37'h80_0000;
                            mv_reg   <= centre_mag(prod_reg[36:0]);
                        end
                        4'd10: acc_reg <= prod_reg;
                        4'd11: wx_reg  <= world_bits(negu_reg, tmp_w);
                        4'd12: acc_reg <= prod_reg;
                        4'd13: begin
                            wz_reg    <= world_bits(negv_reg, tmp_w);
                            res_reg   <= '0;
                            bit_reg   <= 64'h4000_0000_0000_0000;
                            cnt_reg   <= '0;
                            state_reg <= B_SQRT;
                        end
                        default: ;
                    endcase
                end
                B_SQRT: begin
                    // digit-by-digit root, two bits of the radicand per cycle
                    if (l_reg >= sq_try) begin
                        l_reg   <= l_reg - sq_try;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        dsel_reg  <= 2'd0;
                        state_reg <= B_DSET;
                    end
                end
                B_DSET: begin
                    case (dsel_reg)
                        2'd0:    num_reg <= (48'(sx_reg) << 15) + 48'(root >> 1);
                        2'd1:    num_reg <= (48'(sz_reg) << 15) + 48'(root >> 1);
                        default: num_reg <= 48'h8000_0000 + 48'(root >> 1);
                    endcase
                    dv_reg    <= 48'(root) << 16;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    // quotient stays below 2^17, so 17 restoring steps suffice
                    if (num_reg >= dv_reg) begin
                        num_reg <= num_reg - dv_reg;
                    end
                    dv_reg  <= dv_reg >> 1;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16) begin
                        case (dsel_reg)
                            2'd0:    nx_reg <= (quo_next > 17'd32767) ? 15'h7FFF : quo_next[14:0];
                            2'd1:    nz_reg <= (quo_next > 17'd32767) ? 15'h7FFF : quo_next[14:0];
                            default: ny_reg <= (quo_next > 17'd32767) ? 15'h7FFF : quo_next[14:0];
                        endcase
                        dsel_reg  <= dsel_reg + 2'd1;
                        state_reg <= (dsel_reg == 2'd2) ? B_OUT : B_DSET;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
        if (state_reg == B_OUT && out_free) begin
            m_tdata <= {3'd0, tv_reg, tu_reg,
                        negz_reg ? 16'd0 - {1'b0, nz_reg} : {1'b0, nz_reg},
                        ny_reg,
                        negx_reg ? 16'd0 - {1'b0, nx_reg} : {1'b0, nx_reg},
                        wz_reg, wy_reg, wx_reg, job_reg.row, job_reg.col};
            m_tlast <= job_reg.last;
        end
    end

endmodule

// File: rtl/heightmap_terrain_vertex_gen.sv
// Heightmap terrain vertex generator.
// s_ channel: one 16-bit height sample (Q0.16) per beat, raster order, column 0 first.
// m_ channel: one vertex per beat; tlast marks the final vertex caused by an input beat.
// Vertex (x, z-1) leaves once sample (x, z) is in; on the last row each sample
// past column 0 also releases its left neighbour, and the final one its own vertex too.
// Config: cfg_we/cfg_index/cfg_wdata write a register at the clock edge; writing the
// grid width or height restarts the frame at row 0.
// Input side: row-0 samples are only written; later rows read the row stores at x and
// x+1, push to the queue, then write, one more push per extra vertex on the last row.
// Output side: one vertex at a time, through the shared 32x32 multiplier
// sequence (14 steps), the 32-step square root and three 17-step divisions for the normal.
// A four-entry vertex queue sits between the two sides.
// If m_tready stays low, the output register holds its beat, the vertex unit then
// waits, the queue fills and s_tready drops until space returns.
// Reset clears the counters, held samples and queue and loads the default
// configuration; the row stores are not cleared, row 0 fills them.
`include "assert_macros.svh"

module heightmap_terrain_vertex_gen import hvg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // height_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    // col, row, world_x, world_y, world_z, normal_x, normal_y, normal_z, tex_u, tex_v
    output logic [175:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [24:0]  cfg_wdata
);

    cfg_t      cfg_reg;
    logic      restart;
    job_push_t push;
    logic      fifo_full, fifo_empty, pop;
    job_t      head;

    assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width     <= 11'd256;
            cfg_reg.grid_height    <= 13'd256;
            cfg_reg.terrain_size   <= 24'd409600;
            cfg_reg.height_gain    <= 24'd81920;
            cfg_reg.inv_two_step_x <= 24'd83558;
            cfg_reg.inv_two_step_z <= 24'd83558;
            cfg_reg.tex_step_u     <= 25'd65793;
            cfg_reg.tex_step_v     <= 25'd65793;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_WIDTH:     cfg_reg.grid_width     <= cfg_wdata[10:0];
                REG_GRID_HEIGHT:    cfg_reg.grid_height    <= cfg_wdata[12:0];
                REG_TERRAIN_SIZE:   cfg_reg.terrain_size   <= cfg_wdata[23:0];
                REG_HEIGHT_GAIN:    cfg_reg.height_gain    <= cfg_wdata[23:0];
                REG_INV_TWO_STEP_X: cfg_reg.inv_two_step_x <= cfg_wdata[23:0];
                REG_INV_TWO_STEP_Z: cfg_reg.inv_two_step_z <= cfg_wdata[23:0];
                REG_TEX_STEP_U:     cfg_reg.tex_step_u     <= cfg_wdata;
                REG_TEX_STEP_V:     cfg_reg.tex_step_v     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    hvg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .restart   (restart),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .fifo_full (fifo_full)
    );

    hvg_job_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (fifo_full),
        .pop     (pop),
        .empty   (fifo_empty),
        .head    (head)
    );

    hvg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `HVG_ASSERT_NEVER(a_no_push_full, aclk, aresetn, push.valid && fifo_full, "push into full queue")
    `HVG_ASSERT_NEVER(a_no_pop_empty, aclk, aresetn, pop && fifo_empty, "pop from empty queue")
    `HVG_ASSERT_IMPLY(a_idle_no_push, aclk, aresetn, s_tready, !push.valid, "push while front idle")
    `HVG_ASSERT_IMPLY(a_ny_nonzero, aclk, aresetn, m_tvalid, m_tdata[124:110] != 15'd0, "normal y is zero")

endmodule
